// ===== hdl/skm_pkg.sv =====
// Shared types, constants and the saturation helper function of the shifted complex kernel multiply.
// Depends on nothing; every other file of the block but skm_ram refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package skm_pkg;

   localparam int MAX_LINE_DEFAULT = 1024;
   localparam int LEN_W = 11;
   localparam logic [LEN_W-1:0] LINE_LENGTH_RESET = 11'd1024;
   localparam int QUEUE_DEPTH = 2;
   localparam int SAMPLE_W = 16;
   localparam int PROD_W = 32;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_DRAIN  = 1'b1
   } opcode_type;

   typedef struct packed {
      opcode_type                  opcode;
      logic signed [SAMPLE_W-1:0]  img_re;
      logic signed [SAMPLE_W-1:0]  img_im;
      logic signed [SAMPLE_W-1:0]  ker_re;
      logic signed [SAMPLE_W-1:0]  ker_im;
   } req_type;

   typedef struct packed {
      logic signed [PROD_W-1:0] prod_re;
      logic signed [PROD_W-1:0] prod_im;
      logic                     line_end;
   } rsp_type;

   // What the front end has decided about one request.
   typedef struct packed {
      logic emit;       // a stored product of the previous line goes out
      logic line_end;   // that product closes its line
      logic write;      // a new product is stored
   } ctl_type;

   // Clamp a 33-bit sum to the signed 32-bit range.
   function automatic logic signed [PROD_W-1:0] sat33(input logic signed [PROD_W:0] v);
      logic signed [PROD_W-1:0] r;
      if (v > $signed({2'b00, {(PROD_W-1){1'b1}}})) begin
         r = {1'b0, {(PROD_W-1){1'b1}}};
      end else if (v < $signed({2'b11, {(PROD_W-1){1'b0}}})) begin
         r = {1'b1, {(PROD_W-1){1'b0}}};
      end else begin
         r = v[PROD_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/shifted_complex_kernel_multiply_top.sv =====
// Top level of the shifted complex kernel multiply: front end, queue and back end.
// Depends on skm_pkg, skm_front, skm_queue, skm_back and skm_ram.
`timescale 1ns / 1ps
`default_nettype none
// Each sample request carries one Q1.15 complex image sample and one kernel sample; their
// saturated Q2.30 product is stored in one of two line banks, and while one line is being
// written the line before it is read back rotated by half its length, one stored product
// per request, so the block answers a line late. Drain requests produce the remaining
// products of the last line without storing anything; a drain with no line pending is
// accepted and gives no response. The block takes one request per clock cycle for as long
// as responses are taken, and each request passes in order through the two-entry queue,
// the multiplier and bank read stage, and then the response register.
// The rate is set by the single-port-pair bank memory, which takes one write and one read
// per cycle. The banks are not cleared after reset; a product is only read after it was
// written, except in a line cut short, whose unwritten slots return whatever they last held.
// The line length register may only be written while the block is idle.
module shifted_complex_kernel_multiply_top #(
   parameter int MAX_LINE = skm_pkg::MAX_LINE_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire skm_pkg::req_type          req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output skm_pkg::rsp_type               rsp_data,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [skm_pkg::LEN_W-1:0] csr_wdata
);

   // Slot index width; the bank address adds the bank select on top.
   localparam int POS_W = $clog2(MAX_LINE);

   logic             queue_full;
   logic             queue_empty;
   logic             push;
   logic             pop;
   skm_pkg::ctl_type push_ctl;
   skm_pkg::ctl_type head_ctl;
   logic [POS_W:0]   push_rd_addr;
   logic [POS_W:0]   push_wr_addr;
   logic [POS_W:0]   head_rd_addr;
   logic [POS_W:0]   head_wr_addr;
   skm_pkg::req_type head_op;

   // The front end decides, for every request, whether a product goes out and which,
   // and where the new product lands. All line bookkeeping lives there.
   skm_front #(
      .MAX_LINE (MAX_LINE),
      .POS_W    (POS_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_wdata    (csr_wdata),
      .queue_full   (queue_full),
      .push         (push),
      .push_ctl     (push_ctl),
      .push_rd_addr (push_rd_addr),
      .push_wr_addr (push_wr_addr)
   );

   // The queue lets the front end keep accepting, until it is full, while the response side stalls.
   skm_queue #(
      .ADDR_W (POS_W + 1)
   ) u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_ctl     (push_ctl),
      .push_rd_addr (push_rd_addr),
      .push_wr_addr (push_wr_addr),
      .push_op      (req_data),
      .pop          (pop),
      .full         (queue_full),
      .empty        (queue_empty),
      .head_ctl     (head_ctl),
      .head_rd_addr (head_rd_addr),
      .head_wr_addr (head_wr_addr),
      .head_op      (head_op)
   );

   // The back end multiplies, writes the banks and holds the response register.
   skm_back #(
      .MAX_LINE (MAX_LINE),
      .POS_W    (POS_W)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .empty        (queue_empty),
      .pop          (pop),
      .head_ctl     (head_ctl),
      .head_rd_addr (head_rd_addr),
      .head_wr_addr (head_wr_addr),
      .head_op      (head_op),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

endmodule
`default_nettype wire

// ===== hdl/skm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used by the back end for the two line banks.
`timescale 1ns / 1ps
`default_nettype none
module skm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hdl/skm_front.sv =====
// Front end: holds the line length, tracks line position and banks, classifies requests.
// Depends on skm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module skm_front #(
   parameter int MAX_LINE = skm_pkg::MAX_LINE_DEFAULT,
   parameter int POS_W    = $clog2(MAX_LINE)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire skm_pkg::req_type         req_data,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [skm_pkg::LEN_W-1:0] csr_wdata,
   input  wire logic                     queue_full,
   output logic                          push,
   output skm_pkg::ctl_type              push_ctl,
   output logic      [POS_W:0]           push_rd_addr,
   output logic      [POS_W:0]           push_wr_addr
);

   localparam int RESET_LEN_RAW = int'(skm_pkg::LINE_LENGTH_RESET);
   localparam int RESET_EFF = (RESET_LEN_RAW < 1) ? 1 :
                              ((RESET_LEN_RAW > MAX_LINE) ? MAX_LINE : RESET_LEN_RAW);
   localparam logic [POS_W-1:0] RESET_LAST = POS_W'(RESET_EFF - 1);
   localparam logic [POS_W-1:0] RESET_HALF = POS_W'(RESET_EFF / 2);

   logic [POS_W-1:0] last_ff, last_in;
   logic [POS_W-1:0] half_ff, half_in;
   logic [POS_W-1:0] wp_ff, wp_in;
   logic             bank_ff, bank_in;
   logic             prev_ff, prev_in;

   int               len_i;
   int               eff_i;
   logic [POS_W-1:0] pos;
   logic             is_last;
   logic [POS_W:0]   sum;
   logic [POS_W:0]   sum_wrap;
   logic [POS_W-1:0] src;
   logic             drain;
   logic             fire;
   logic             live;

   assign csr_ready = 1'b1;
   assign req_ready = !queue_full;

   // Effective length is worked out once, when the register is written.
   always_comb begin
      len_i = int'(csr_wdata);
      if (len_i < 1) begin
         eff_i = 1;
      end else if (len_i > MAX_LINE) begin
         eff_i = MAX_LINE;
      end else begin
         eff_i = len_i;
      end
      last_in = last_ff;
      half_in = half_ff;
      if (csr_valid) begin
         last_in = POS_W'(eff_i - 1);
         half_in = POS_W'(eff_i >> 1);
      end
   end

   always_comb begin
      pos      = (wp_ff > last_ff) ? last_ff : wp_ff;
      is_last  = (pos == last_ff);
      sum      = {1'b0, pos} + {1'b0, half_ff};
      sum_wrap = sum - ({1'b0, last_ff} + (POS_W+1)'(1));
      src      = (sum > {1'b0, last_ff}) ? sum_wrap[POS_W-1:0] : sum[POS_W-1:0];
      drain    = (req_data.opcode == skm_pkg::OP_DRAIN);
      fire     = req_valid && req_ready;
      // A drain with nothing buffered is taken and forgotten.
      live     = !(drain && !prev_ff);
      push     = fire && live;

      push_ctl.emit     = prev_ff;
      push_ctl.line_end = is_last;
      push_ctl.write    = !drain;
      push_rd_addr      = {!bank_ff, src};
      push_wr_addr      = {bank_ff, pos};

      wp_in   = wp_ff;
      bank_in = bank_ff;
      prev_in = prev_ff;
      if (push) begin
         if (is_last) begin
            wp_in   = '0;
            bank_in = !bank_ff;
            prev_in = !drain;
         end else begin
            wp_in = pos + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= RESET_LAST;
         half_ff <= RESET_HALF;
         wp_ff   <= '0;
         bank_ff <= 1'b0;
         prev_ff <= 1'b0;
      end else begin
         last_ff <= last_in;
         half_ff <= half_in;
         wp_ff   <= wp_in;
         bank_ff <= bank_in;
         prev_ff <= prev_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/skm_queue.sv =====
// Short queue between front and back end, carrying decisions, addresses and operands.
// Depends on skm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module skm_queue #(
   parameter int ADDR_W = 11
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire skm_pkg::ctl_type     push_ctl,
   input  wire logic [ADDR_W-1:0]    push_rd_addr,
   input  wire logic [ADDR_W-1:0]    push_wr_addr,
   input  wire skm_pkg::req_type     push_op,
   input  wire logic                 pop,
   output logic                      full,
   output logic                      empty,
   output skm_pkg::ctl_type          head_ctl,
   output logic      [ADDR_W-1:0]    head_rd_addr,
   output logic      [ADDR_W-1:0]    head_wr_addr,
   output skm_pkg::req_type          head_op
);

   localparam int PTR_W = $clog2(skm_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(skm_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(skm_pkg::QUEUE_DEPTH - 1);

   skm_pkg::ctl_type ctl_ff  [skm_pkg::QUEUE_DEPTH];
   logic [ADDR_W-1:0] rd_ff  [skm_pkg::QUEUE_DEPTH];
   logic [ADDR_W-1:0] wr_ff  [skm_pkg::QUEUE_DEPTH];
   skm_pkg::req_type op_ff   [skm_pkg::QUEUE_DEPTH];

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      full    = (count_ff == CNT_W'(skm_pkg::QUEUE_DEPTH));
      empty   = (count_ff == '0);
      head_in = head_ff;
      tail_in = tail_ff;
      if (push) begin
         tail_in = (tail_ff == PTR_LAST) ? '0 : tail_ff + PTR_W'(1);
      end
      if (pop) begin
         head_in = (head_ff == PTR_LAST) ? '0 : head_ff + PTR_W'(1);
      end
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ctl_ff[tail_ff] <= push_ctl;
         rd_ff[tail_ff]  <= push_rd_addr;
         wr_ff[tail_ff]  <= push_wr_addr;
         op_ff[tail_ff]  <= push_op;
      end
   end

   assign head_ctl     = ctl_ff[head_ff];
   assign head_rd_addr = rd_ff[head_ff];
   assign head_wr_addr = wr_ff[head_ff];
   assign head_op      = op_ff[head_ff];

endmodule
`default_nettype wire

// ===== hdl/skm_back.sv =====
// Back end: complex multiply, line bank store and read-out, response register.
// Depends on skm_pkg and skm_ram.
`timescale 1ns / 1ps
`default_nettype none
module skm_back #(
   parameter int MAX_LINE = skm_pkg::MAX_LINE_DEFAULT,
   parameter int POS_W    = $clog2(MAX_LINE)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             empty,
   output logic                  pop,
   input  wire skm_pkg::ctl_type head_ctl,
   input  wire logic [POS_W:0]   head_rd_addr,
   input  wire logic [POS_W:0]   head_wr_addr,
   input  wire skm_pkg::req_type head_op,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output skm_pkg::rsp_type      rsp_data
);

   localparam int PW = skm_pkg::PROD_W;
   localparam int RAM_DEPTH = 2 ** (POS_W + 1);

   logic                     adv;
   logic                     s1_valid_ff, s1_valid_in;
   skm_pkg::ctl_type         s1_ctl_ff;
   logic [POS_W:0]           s1_wr_addr_ff;
   logic signed [PW-1:0]     mul_ac_ff, mul_bd_ff, mul_ad_ff, mul_bc_ff;
   logic signed [PW:0]       sum_re, sum_im;
   logic [2*PW-1:0]          wr_word;
   logic [2*PW-1:0]          rd_word;
   logic                     fwd_ff, fwd_in;
   logic [2*PW-1:0]          fwd_word_ff;
   logic [2*PW-1:0]          out_word;
   logic                     rsp_valid_ff, rsp_valid_in;
   skm_pkg::rsp_type         rsp_data_ff;

   // The whole back end moves as one when the response register is free.
   assign adv = !rsp_valid_ff || rsp_ready;
   assign pop = adv && !empty;

   always_comb begin
      s1_valid_in = adv ? pop : s1_valid_ff;
      sum_re  = PW'(0) + (PW+1)'(mul_ac_ff) - (PW+1)'(mul_bd_ff);
      sum_im  = (PW+1)'(mul_ad_ff) + (PW+1)'(mul_bc_ff);
      wr_word = {skm_pkg::sat33(sum_re), skm_pkg::sat33(sum_im)};
      // The next read hits the entry this very edge writes: take the new value.
      fwd_in  = s1_valid_ff && s1_ctl_ff.write && (s1_wr_addr_ff == head_rd_addr);
      out_word = fwd_ff ? fwd_word_ff : rd_word;
      rsp_valid_in = adv ? (s1_valid_ff && s1_ctl_ff.emit) : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ctl_ff     <= head_ctl;
         s1_wr_addr_ff <= head_wr_addr;
         mul_ac_ff     <= PW'(head_op.img_re) * PW'(head_op.ker_re);
         mul_bd_ff     <= PW'(head_op.img_im) * PW'(head_op.ker_im);
         mul_ad_ff     <= PW'(head_op.img_re) * PW'(head_op.ker_im);
         mul_bc_ff     <= PW'(head_op.img_im) * PW'(head_op.ker_re);
         fwd_ff        <= fwd_in;
         fwd_word_ff   <= wr_word;
         rsp_data_ff.prod_re  <= out_word[2*PW-1:PW];
         rsp_data_ff.prod_im  <= out_word[PW-1:0];
         rsp_data_ff.line_end <= s1_ctl_ff.line_end;
      end
   end

   skm_ram #(
      .WIDTH (2 * PW),
      .DEPTH (RAM_DEPTH)
   ) u_bank (
      .clock   (clock),
      .wr_en   (adv && s1_valid_ff && s1_ctl_ff.write),
      .wr_addr (s1_wr_addr_ff),
      .wr_data (wr_word),
      .rd_en   (adv),
      .rd_addr (head_rd_addr),
      .rd_data (rd_word)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== hdl/skm_checker.sv =====
// Port-level checks of the shifted complex kernel multiply, and their binding to the top.
// Depends on skm_pkg and shifted_complex_kernel_multiply_top.
`timescale 1ns / 1ps
`default_nettype none
module skm_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_ready,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire skm_pkg::rsp_type          rsp_data,
   input wire logic                      csr_valid,
   input wire logic                      csr_ready
);

   // Requests taken but not yet matched by a response (some never will be).
   logic [31:0] pend_ff, pend_in;
   logic        req_fire;
   logic        rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      pend_in = pend_ff;
      if (req_fire && !rsp_fire) begin
         pend_in = pend_ff + 32'd1;
      end else if (rsp_fire && !req_fire && pend_ff != 32'd0) begin
         pend_in = pend_ff - 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // A stalled response holds its data.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   // No response without an earlier request behind it.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 32'd0)
      else $error("response without a pending request");

   // Reset empties the response side.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // The line length register never stalls a write.
   a_csr_open: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration write refused");

endmodule

bind shifted_complex_kernel_multiply_top skm_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready)
);
`default_nettype wire
